// ----- sv/mbb_pkg.sv -----
// ---------------------------------------------------------------------------
// Monochrome bitmap blit package
// Shared constants, codes and types for the paged framebuffer blitter.
// ---------------------------------------------------------------------------
package mbb_pkg;

  // Default geometry of the display and of the image words.
  localparam int FB_WIDTH_DEF  = 128;
  localparam int FB_HEIGHT_DEF = 64;
  localparam int WORD_BITS_DEF = 8;

  // Framebuffer organization: pages of eight vertical pixels per byte.
  localparam int FB_BYTES    = 1024;
  localparam int FB_ADDR_W   = $clog2(FB_BYTES);
  localparam int PAGE_STRIDE = 128;
  localparam int PAGE_SHIFT  = $clog2(PAGE_STRIDE);
  localparam int PIX_BITS    = 8;
  localparam int ROW_SHIFT   = $clog2(PIX_BITS);

  // Signed display coordinate: 10-bit offset plus 8-bit image position.
  localparam int COORD_W = 11;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X        = 3'd0,
    REG_POS_Y        = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_CLIP_WIDTH   = 3'd4,
    REG_CLIP_HEIGHT  = 3'd5,
    REG_DRAW_MODE    = 3'd6
  } reg_idx_t;

  // Draw mode codes. Bit one of the mode selects clearing.
  localparam logic [1:0] MODE_HIDDEN    = 2'd0;
  localparam logic [1:0] MODE_SET       = 2'd1;
  localparam int         MODE_CLEAR_BIT = 1;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic [7:0]        image_width;
    logic [7:0]        image_height;
    logic [7:0]        clip_width;
    logic [7:0]        clip_height;
    logic [1:0]        draw_mode;
  } cfg_t;

  // Outcome of placing one pixel on the display.
  typedef struct packed {
    logic                 hit;
    logic [FB_ADDR_W-1:0] addr;
    logic [PIX_BITS-1:0]  mask;
  } place_t;

endpackage

// ----- sv/mbb_in_if.sv -----
// ---------------------------------------------------------------------------
// Blitter request channel
// Carries the request kind, the data byte and the framebuffer address.
// ---------------------------------------------------------------------------
interface mbb_in_if;
  import mbb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [7:0]           data_byte;
  logic [FB_ADDR_W-1:0] address;

  modport source (output valid, output kind, output data_byte, output address,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input address,
                  output ready);
endinterface

// ----- sv/mbb_out_if.sv -----
// ---------------------------------------------------------------------------
// Blitter result channel
// Carries the read data and the render completion flag of each request.
// ---------------------------------------------------------------------------
interface mbb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       render_done;

  modport source (output valid, output read_data, output render_done,
                  input ready);
  modport sink   (input valid, input read_data, input render_done,
                  output ready);
endinterface

// ----- sv/mbb_cfg_if.sv -----
// ---------------------------------------------------------------------------
// Blitter configuration write channel
// Carries a register index and the data written to it.
// ---------------------------------------------------------------------------
interface mbb_cfg_if;
  import mbb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mbb_place.sv -----
// ---------------------------------------------------------------------------
// Blitter pixel placement unit
// Offsets an image pixel onto the display, clips it and forms the byte
// address and bit mask in the paged framebuffer.
// ---------------------------------------------------------------------------
module mbb_place #(
  parameter int FB_WIDTH  = mbb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = mbb_pkg::FB_HEIGHT_DEF
) (
  input  mbb_pkg::cfg_t   cfg,
  input  logic [7:0]      col,
  input  logic [7:0]      row,
  output mbb_pkg::place_t place
);
  import mbb_pkg::*;

  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic [COORD_W-1:0] clip_w;
  logic [COORD_W-1:0] clip_h;

  // Display position of the pixel, two's complement.
  always_comb begin
    px = {{(COORD_W-10){cfg.pos_x[9]}}, cfg.pos_x} + {{(COORD_W-8){1'b0}}, col};
    py = {{(COORD_W-10){cfg.pos_y[9]}}, cfg.pos_y} + {{(COORD_W-8){1'b0}}, row};
  end

  // Clip window; zero or an oversized value selects the whole display.
  always_comb begin
    if (cfg.clip_width == 8'd0 ||
        COORD_W'(cfg.clip_width) > COORD_W'(FB_WIDTH)) begin
      clip_w = COORD_W'(FB_WIDTH);
    end else begin
      clip_w = COORD_W'(cfg.clip_width);
    end
    if (cfg.clip_height == 8'd0 ||
        COORD_W'(cfg.clip_height) > COORD_W'(FB_HEIGHT)) begin
      clip_h = COORD_W'(FB_HEIGHT);
    end else begin
      clip_h = COORD_W'(cfg.clip_height);
    end
  end

  // Window test, page address (wrapping over the buffer) and bit mask.
  always_comb begin
    place.hit  = !px[COORD_W-1] && (px < clip_w) && !py[COORD_W-1] && (py < clip_h);
    place.addr = FB_ADDR_W'(FB_ADDR_W'(py[COORD_W-1:ROW_SHIFT]) << PAGE_SHIFT)
               + px[FB_ADDR_W-1:0];
    place.mask = PIX_BITS'(1) << py[ROW_SHIFT-1:0];
  end

endmodule

// ----- sv/mono_bitmap_blit_paged_core.sv -----
// ---------------------------------------------------------------------------
// Monochrome bitmap blitter with paged framebuffer
// Draws 1-bit images into a 1024-byte page-organized framebuffer and gives
// bus read and write access to it. Every request returns one result.
// ---------------------------------------------------------------------------
// The block handles one request at a time and drops ready while it works.
// An image data byte walks its WORD_BITS pixels one per cycle through a small
// sequencer while no pixel is drawn; a visible set pixel adds a step for
// placement and clipping, and one more if it lands inside the clip window,
// because every drawn pixel is a read-modify-write of the single-port
// framebuffer. After reset the framebuffer is cleared one byte per cycle, so
// requests are first accepted once all 1024 bytes are cleared; configuration
// writes are taken at any time. A finished result sits in an output register,
// and the next request is accepted while it waits.
// ---------------------------------------------------------------------------
module mono_bitmap_blit_paged_core #(
  parameter int FB_WIDTH  = mbb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = mbb_pkg::FB_HEIGHT_DEF,
  parameter int WORD_BITS = mbb_pkg::WORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mbb_in_if.sink    in_chan,
  mbb_out_if.source out_chan,
  mbb_cfg_if.sink   cfg_chan
);
  import mbb_pkg::*;

  localparam int                   K_W      = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [K_W-1:0]       K_LAST   = K_W'(WORD_BITS - 1);
  localparam logic [FB_ADDR_W-1:0] CLR_LAST = FB_ADDR_W'(FB_BYTES - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WALK  = 6'b000100,
    S_PLACE = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [FB_ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  cfg_t                 cfg_r;
  logic [7:0]           col_r, col_nxt;
  logic [7:0]           row_r, row_nxt;
  logic                 complete_r, complete_nxt;
  logic [PIX_BITS-1:0]  byte_r, byte_nxt;
  logic [K_W-1:0]       k_r, k_nxt;
  logic                 last_r, last_nxt;
  logic [7:0]           pix_col_r, pix_col_nxt;
  logic [7:0]           pix_row_r, pix_row_nxt;
  logic [FB_ADDR_W-1:0] addr_r, addr_nxt;
  logic [PIX_BITS-1:0]  mask_r, mask_nxt;
  logic                 is_read_r, is_read_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           read_data_r, read_data_nxt;
  logic                 render_done_r, render_done_nxt;

  logic [PIX_BITS-1:0]  fb_mem [FB_BYTES];
  logic [PIX_BITS-1:0]  mem_q_r;
  logic                 mem_we;
  logic                 mem_re;
  logic [FB_ADDR_W-1:0] mem_addr;
  logic [PIX_BITS-1:0]  mem_wdata;

  logic                 in_acc;
  logic                 cfg_acc;
  place_t               place;

  // Handshakes.
  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign cfg_acc        = cfg_chan.valid && cfg_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_data   = read_data_r;
  assign out_chan.render_done = render_done_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_x        <= '0;
      cfg_r.pos_y        <= '0;
      cfg_r.image_width  <= '0;
      cfg_r.image_height <= '0;
      cfg_r.clip_width   <= '0;
      cfg_r.clip_height  <= '0;
      cfg_r.draw_mode    <= MODE_SET;
    end else if (cfg_acc) begin
      unique case (reg_idx_t'(cfg_chan.index))
        REG_POS_X:        cfg_r.pos_x        <= cfg_chan.data;
        REG_POS_Y:        cfg_r.pos_y        <= cfg_chan.data;
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_chan.data[7:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_chan.data[7:0];
        REG_CLIP_WIDTH:   cfg_r.clip_width   <= cfg_chan.data[7:0];
        REG_CLIP_HEIGHT:  cfg_r.clip_height  <= cfg_chan.data[7:0];
        REG_DRAW_MODE:    cfg_r.draw_mode    <= cfg_chan.data[1:0];
        default: ;
      endcase
    end
  end

  // Pixel placement and clipping.
  mbb_place #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_place (
    .cfg   (cfg_r),
    .col   (pix_col_r),
    .row   (pix_row_r),
    .place (place)
  );

  // Sequencer: clearing pass, request decode, pixel walk and read-modify-write.
  always_comb begin
    logic [7:0] c0;
    logic [7:0] r0;
    logic [7:0] c1;
    logic       wrap0;

    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    complete_nxt    = complete_r;
    byte_nxt        = byte_r;
    k_nxt           = k_r;
    last_nxt        = last_r;
    pix_col_nxt     = pix_col_r;
    pix_row_nxt     = pix_row_r;
    addr_nxt        = addr_r;
    mask_nxt        = mask_r;
    is_read_nxt     = is_read_r;
    out_valid_nxt   = out_valid_r;
    read_data_nxt   = read_data_r;
    render_done_nxt = render_done_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = addr_r;
    mem_wdata       = '0;
    wrap0           = col_r >= cfg_r.image_width;
    c0              = wrap0 ? 8'd0 : col_r;
    r0              = wrap0 ? row_r + 8'd1 : row_r;
    c1              = c0 + 8'd1;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          is_read_nxt = 1'b0;
          unique case (kind_t'(in_chan.kind))
            KIND_START: begin
              col_nxt      = '0;
              row_nxt      = '0;
              complete_nxt = (cfg_r.image_width == 8'd0) || (cfg_r.image_height == 8'd0);
              state_nxt    = S_DONE;
            end
            KIND_DATA: begin
              byte_nxt  = in_chan.data_byte;
              k_nxt     = '0;
              state_nxt = S_WALK;
            end
            KIND_READ: begin
              mem_re      = 1'b1;
              mem_addr    = in_chan.address;
              is_read_nxt = 1'b1;
              state_nxt   = S_DONE;
            end
            KIND_WRITE: begin
              mem_we    = 1'b1;
              mem_addr  = in_chan.address;
              mem_wdata = in_chan.data_byte;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // One pixel of the current byte: advance the walk, decide on drawing.
      S_WALK: begin
        k_nxt    = k_r + 1'b1;
        last_nxt = (k_r == K_LAST);
        byte_nxt = byte_r << 1;
        if (complete_r) begin
          state_nxt = S_DONE;
        end else if (cfg_r.image_width == 8'd0 || row_r >= cfg_r.image_height) begin
          complete_nxt = 1'b1;
          state_nxt    = S_DONE;
        end else if (wrap0 && r0 >= cfg_r.image_height) begin
          col_nxt      = c0;
          row_nxt      = r0;
          complete_nxt = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          pix_col_nxt = c0;
          pix_row_nxt = r0;
          if (c1 >= cfg_r.image_width) begin
            col_nxt      = '0;
            row_nxt      = r0 + 8'd1;
            complete_nxt = (r0 + 8'd1) >= cfg_r.image_height;
          end else begin
            col_nxt = c1;
            row_nxt = r0;
          end
          if (byte_r[PIX_BITS-1] && cfg_r.draw_mode != MODE_HIDDEN) begin
            state_nxt = S_PLACE;
          end else if (k_r == K_LAST) begin
            state_nxt = S_DONE;
          end
        end
      end

      // Clip the pixel and fetch its framebuffer byte.
      S_PLACE: begin
        if (place.hit) begin
          mem_re    = 1'b1;
          mem_addr  = place.addr;
          addr_nxt  = place.addr;
          mask_nxt  = place.mask;
          state_nxt = S_WRITE;
        end else begin
          state_nxt = last_r ? S_DONE : S_WALK;
        end
      end

      // Write back the byte with the pixel set or cleared.
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = cfg_r.draw_mode[MODE_CLEAR_BIT] ? (mem_q_r & ~mask_r)
                                                    : (mem_q_r | mask_r);
        state_nxt = last_r ? S_DONE : S_WALK;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          read_data_nxt   = is_read_r ? mem_q_r : 8'd0;
          render_done_nxt = complete_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      col_r       <= '0;
      row_r       <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      complete_r  <= complete_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    byte_r        <= byte_nxt;
    k_r           <= k_nxt;
    last_r        <= last_nxt;
    pix_col_r     <= pix_col_nxt;
    pix_row_r     <= pix_row_nxt;
    addr_r        <= addr_nxt;
    mask_r        <= mask_nxt;
    is_read_r     <= is_read_nxt;
    read_data_r   <= read_data_nxt;
    render_done_r <= render_done_nxt;
  end

  // Single-port framebuffer with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fb_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= fb_mem[mem_addr];
    end
  end

  // The framebuffer port serves one access per cycle.
  a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("framebuffer read and write in the same cycle");

  // A pixel write changes exactly one bit of its byte.
  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> $onehot(mask_r))
    else $error("pixel mask is not a single bit");

  // An accepted request moves the sequencer to the pixel walk or the result.
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_acc) |=> (state_r == S_WALK || state_r == S_DONE))
    else $error("accepted request did not start processing");

  // Render completion drops only on reset or a start request.
  a_done_falls: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(complete_r) |->
      (!$past(rst_n) || $past(in_acc && in_chan.kind == KIND_START)))
    else $error("render completion cleared without a start request");

  // A waiting result is never overwritten.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_chan.ready) |=> (state_r == S_DONE))
    else $error("result produced while output register was full");

endmodule

// ----- verif/mbb_blit_checker.sv -----
// ---------------------------------------------------------------------------
// Blitter result checker
// Watches the configuration, request and result channels of the paged
// bitmap blitter. It keeps its own copy of the framebuffer, the image walk and
// the registers, works out the result of every accepted request and compares
// each accepted result, field by field, with the oldest one still waiting.
// ---------------------------------------------------------------------------
module mbb_blit_checker (
  input  logic clk,
  input  logic rst_n,
  mbb_in_if    in_mon,
  mbb_out_if   out_mon,
  mbb_cfg_if   cfg_mon,
  output int   fail_count
);
  import mbb_pkg::*;

  localparam int FB_W      = FB_WIDTH_DEF;
  localparam int FB_H      = FB_HEIGHT_DEF;
  localparam int WORD_BITS = WORD_BITS_DEF;

  typedef struct packed {
    logic [7:0] read_data;
    logic       render_done;
  } blit_result_t;

  blit_result_t pending_results[$];
  logic [7:0]   fb_copy[FB_BYTES];
  cfg_t         regs;
  int unsigned  walk_col;
  int unsigned  walk_row;
  logic         image_done;
  int           mismatches = 0;
  int           outstanding = 0;

  // Anything still waiting at the end counts against the run as well.
  assign fail_count = mismatches + outstanding;

  // Place one image pixel on the display, honoring the offset and the clip window.
  function automatic void plot_pixel(int unsigned col, int unsigned row);
    int         clip_w;
    int         clip_h;
    int         px;
    int         py;
    int         byte_idx;
    logic [7:0] bit_mask;
    clip_w = regs.clip_width;
    clip_h = regs.clip_height;
    if (clip_w == 0 || clip_w > FB_W) clip_w = FB_W;
    if (clip_h == 0 || clip_h > FB_H) clip_h = FB_H;
    px = int'($signed(regs.pos_x)) + int'(col);
    py = int'($signed(regs.pos_y)) + int'(row);
    if (px < 0 || px >= clip_w || py < 0 || py >= clip_h) return;
    byte_idx = ((py / PIX_BITS) * PAGE_STRIDE + px) % FB_BYTES;
    bit_mask = 8'(1 << (py % PIX_BITS));
    if (regs.draw_mode[MODE_CLEAR_BIT]) begin
      fb_copy[byte_idx] = fb_copy[byte_idx] & ~bit_mask;
    end else begin
      fb_copy[byte_idx] = fb_copy[byte_idx] | bit_mask;
    end
  endfunction

  // Walk the pixels of one image byte, most significant bit first.
  function automatic void walk_byte(logic [7:0] pixels);
    for (int k = 0; k < WORD_BITS && k < 8; k++) begin
      if (image_done) return;
      if (regs.image_width == 0 || walk_row >= regs.image_height) begin
        image_done = 1'b1;
        return;
      end
      // The width may have shrunk under a walk in progress.
      if (walk_col >= regs.image_width) begin
        walk_col = 0;
        walk_row++;
        if (walk_row >= regs.image_height) begin
          image_done = 1'b1;
          return;
        end
      end
      if (pixels[7-k] && regs.draw_mode != MODE_HIDDEN) plot_pixel(walk_col, walk_row);
      walk_col++;
      if (walk_col >= regs.image_width) begin
        walk_col = 0;
        walk_row++;
        if (walk_row >= regs.image_height) image_done = 1'b1;
      end
    end
  endfunction

  // Apply one request to the copied state and return the result it yields.
  function automatic blit_result_t predict_result(kind_t kind, logic [7:0] data,
                                                  logic [FB_ADDR_W-1:0] addr);
    blit_result_t res;
    res.read_data = '0;
    case (kind)
      KIND_START: begin
        walk_col   = 0;
        walk_row   = 0;
        image_done = (regs.image_width == 0 || regs.image_height == 0);
      end
      KIND_DATA:  walk_byte(data);
      KIND_READ:  res.read_data = fb_copy[addr];
      KIND_WRITE: fb_copy[addr] = data;
      default: ;
    endcase
    res.render_done = image_done;
    return res;
  endfunction

  // Follow the channels at every rising edge. Results are compared before the
  // request of the same edge is added, so a request never matches itself.
  always @(posedge clk) begin
    blit_result_t want;
    if (!rst_n) begin
      foreach (fb_copy[i]) fb_copy[i] = '0;
      regs            = '0;
      regs.draw_mode  = MODE_SET;
      walk_col        = 0;
      walk_row        = 0;
      image_done      = 1'b0;
      pending_results.delete();
      outstanding     = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (reg_idx_t'(cfg_mon.index))
          REG_POS_X:        regs.pos_x        = cfg_mon.data;
          REG_POS_Y:        regs.pos_y        = cfg_mon.data;
          REG_IMAGE_WIDTH:  regs.image_width  = cfg_mon.data[7:0];
          REG_IMAGE_HEIGHT: regs.image_height = cfg_mon.data[7:0];
          REG_CLIP_WIDTH:   regs.clip_width   = cfg_mon.data[7:0];
          REG_CLIP_HEIGHT:  regs.clip_height  = cfg_mon.data[7:0];
          REG_DRAW_MODE:    regs.draw_mode    = cfg_mon.data[1:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: read_data %0h, render_done %0b",
                 out_mon.read_data, out_mon.render_done);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          outstanding--;
          if (out_mon.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %0h, actual %0h",
                   want.read_data, out_mon.read_data);
            mismatches++;
          end
          if (out_mon.render_done !== want.render_done) begin
            $error("render_done mismatch: expected %0b, actual %0b",
                   want.render_done, out_mon.render_done);
            mismatches++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(predict_result(kind_t'(in_mon.kind), in_mon.data_byte,
                                                 in_mon.address));
        outstanding++;
      end
    end
  end

endmodule

// ----- verif/mono_bitmap_blit_paged_core_test.sv -----
// ---------------------------------------------------------------------------
// Paged bitmap blitter testbench
// Drives start, image, read and write requests into the blitter under a range
// of register settings: first a short directed run over the corner cases of
// the image walk, then random images with bus traffic mixed in. Both sides
// idle at random and the result side holds off once for a long stretch. A
// separate checker predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module mono_bitmap_blit_paged_core_test;
  import mbb_pkg::*;

  localparam int IDLE_LIMIT    = 6000;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_BYTES     = 96;

  localparam logic [1:0] MODE_CLEAR     = 2'd2;
  localparam logic [1:0] MODE_CLEAR_ALT = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  int   sent = 0;
  int   received = 0;
  int   fail_count;
  int   tx_calm = 0;
  int   rx_calm = 0;
  int   rx_hold = 0;
  int   idle_cycles = 0;

  always #6 clk = ~clk;

  mbb_in_if  in_chan();
  mbb_out_if out_chan();
  mbb_cfg_if cfg_chan();

  mono_bitmap_blit_paged_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  mbb_blit_checker blit_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fail_count)
  );

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and wait for it to be taken. Valid stays high afterwards
  // so that a following request without a gap goes out back to back.
  task automatic send_req(kind_t kind, logic [7:0] data, logic [FB_ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.kind      <= kind;
    in_chan.data_byte <= data;
    in_chan.address   <= addr;
    do @(posedge clk); while (!in_chan.ready);
    sent++;
  endtask

  // Stop offering and wait until the block has nothing left in flight.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (received != sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper data bits of the narrow registers carry random values.
  task automatic configure(logic [9:0] px, logic [9:0] py, logic [7:0] w, logic [7:0] h,
                           logic [7:0] cw, logic [7:0] ch, logic [1:0] mode);
    cfg_write(REG_POS_X, px);
    cfg_write(REG_POS_Y, py);
    cfg_write(REG_IMAGE_WIDTH, {2'($urandom), w});
    cfg_write(REG_IMAGE_HEIGHT, {2'($urandom), h});
    cfg_write(REG_CLIP_WIDTH, {2'($urandom), cw});
    cfg_write(REG_CLIP_HEIGHT, {2'($urandom), ch});
    cfg_write(REG_DRAW_MODE, {8'($urandom), mode});
  endtask

  // Pick a random image placement and return how many bytes to feed it.
  // Most images are small; the largest sizes appear with few bytes fed.
  task automatic random_image(output int n_bytes);
    int         r;
    logic [9:0] px;
    logic [9:0] py;
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] cw;
    logic [7:0] ch;
    logic [1:0] mode;
    w = 8'($urandom_range(1, 32));
    h = 8'($urandom_range(1, 16));
    r = $urandom_range(0, 19);
    if (r == 0) w = 8'd0;
    else if (r == 1) h = 8'd0;
    else if (r == 2) w = 8'd255;
    else if (r == 3) h = 8'd255;
    else if (r == 4) begin
      w = 8'd255;
      h = 8'd255;
    end
    px = ($urandom_range(0, 6) == 0) ? 10'($urandom) : 10'($urandom_range(0, 160) - 24);
    py = ($urandom_range(0, 6) == 0) ? 10'($urandom) : 10'($urandom_range(0, 90) - 16);
    r  = $urandom_range(0, 4);
    cw = (r < 2) ? 8'd0 : (r == 2) ? 8'($urandom) : 8'($urandom_range(1, FB_WIDTH_DEF));
    r  = $urandom_range(0, 4);
    ch = (r < 2) ? 8'd0 : (r == 2) ? 8'($urandom) : 8'($urandom_range(1, FB_HEIGHT_DEF));
    r  = $urandom_range(0, 9);
    mode = (r < 6) ? MODE_SET : (r < 8) ? MODE_CLEAR : (r == 8) ? MODE_HIDDEN : MODE_CLEAR_ALT;
    configure(px, py, w, h, cw, ch, mode);
    n_bytes = (int'(w) * int'(h) + 7) / 8 + $urandom_range(0, 3);
    if (n_bytes > MAX_BYTES) n_bytes = MAX_BYTES;
  endtask

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        gap = pick_gap(rx_calm);
        if (gap > 0) begin
          out_chan.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      received++;
    end
  end

  // Watchdog: ends the run when no channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    int n_bytes;
    int first_random;
    int r;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.kind      <= KIND_START;
    in_chan.data_byte <= '0;
    in_chan.address   <= '0;
    cfg_chan.valid    <= 1'b0;
    cfg_chan.index    <= REG_POS_X;
    cfg_chan.data     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // A 12 x 3 image: one byte before any start, then a walk that ends inside
    // a byte, and one byte after the image is complete.
    configure(10'd0, 10'd0, 8'd12, 8'd3, 8'd0, 8'd0, MODE_SET);
    send_req(KIND_DATA, 8'hA5, 10'd0);
    send_req(KIND_START, 8'h00, 10'd0);
    send_req(KIND_DATA, 8'hFF, 10'd0);
    send_req(KIND_DATA, 8'h00, 10'd0);
    send_req(KIND_DATA, 8'h80, 10'd0);
    send_req(KIND_DATA, 8'h01, 10'd0);
    send_req(KIND_DATA, 8'h7E, 10'd0);
    send_req(KIND_DATA, 8'hFF, 10'd0);
    send_req(KIND_READ, 8'h00, 10'd0);
    send_req(KIND_READ, 8'h00, 10'd1);

    // Bus access at the address extremes, and bytes to be cleared below.
    send_req(KIND_WRITE, 8'hFF, 10'd1023);
    send_req(KIND_READ, 8'h00, 10'd1023);
    send_req(KIND_WRITE, 8'hFF, 10'd2);
    send_req(KIND_WRITE, 8'hFF, 10'd3);

    // Offsets and sizes at their extremes, in mode three: nothing lands.
    settle();
    configure(10'h200, 10'h1FF, 8'd255, 8'd255, 8'd255, 8'd255, MODE_CLEAR_ALT);
    send_req(KIND_START, 8'h00, 10'd0);
    send_req(KIND_DATA, 8'hFF, 10'd0);

    // Clearing inside a small clip window while the image shrinks mid-walk.
    settle();
    configure(10'h3FF, 10'd1, 8'd10, 8'd8, 8'd6, 8'd5, MODE_CLEAR);
    send_req(KIND_START, 8'h00, 10'd0);
    send_req(KIND_DATA, 8'hF0, 10'd0);
    settle();
    cfg_write(REG_IMAGE_WIDTH, 10'd4);
    send_req(KIND_DATA, 8'hFF, 10'd0);
    settle();
    cfg_write(REG_IMAGE_HEIGHT, 10'd1);
    send_req(KIND_DATA, 8'h55, 10'd0);
    send_req(KIND_READ, 8'h00, 10'd2);

    // Hidden mode walks without drawing.
    settle();
    configure(10'd0, 10'd0, 8'd8, 8'd8, 8'd0, 8'd0, MODE_HIDDEN);
    send_req(KIND_START, 8'h00, 10'd0);
    send_req(KIND_DATA, 8'hFF, 10'd0);

    // A zero width completes at the start.
    settle();
    cfg_write(REG_IMAGE_WIDTH, 10'd0);
    cfg_write(REG_DRAW_MODE, {8'h00, MODE_SET});
    send_req(KIND_START, 8'h00, 10'd0);
    send_req(KIND_DATA, 8'hFF, 10'd0);

    // Random images. The result side holds off once early on so that the
    // block fills up and stalls its request side.
    rx_hold = HOLD_CYCLES;
    first_random = sent;
    while (sent - first_random < RANDOM_ITEMS) begin
      settle();
      random_image(n_bytes);
      send_req(KIND_START, 8'($urandom), 10'($urandom));
      for (int i = 0; i < n_bytes; i++) begin
        if (i == n_bytes / 2 && $urandom_range(0, 7) == 0) begin
          settle();
          cfg_write($urandom_range(0, 1) ? REG_IMAGE_WIDTH : REG_IMAGE_HEIGHT,
                    10'($urandom_range(0, 40)));
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_req(KIND_READ, 8'($urandom), 10'($urandom));
        end else if (r < 12) begin
          send_req(KIND_WRITE, 8'($urandom), 10'($urandom));
        end else if (r < 14) begin
          send_req(kind_t'($urandom_range(0, 3)), 8'($urandom), 10'($urandom));
        end else if (r < 24) begin
          send_req(KIND_DATA, 8'hFF, 10'($urandom));
        end else if (r < 29) begin
          send_req(KIND_DATA, 8'h00, 10'($urandom));
        end else begin
          send_req(KIND_DATA, 8'($urandom), 10'($urandom));
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
